[rtl/core/wahenc_pkg.sv]
`default_nettype none
package wahenc_pkg;

  // Word layout
  localparam int WORD_W = 64;
  localparam int LIT_W  = WORD_W - 1;
  localparam int FCNT_W = WORD_W - 2;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int CNT_W  = 6;
  localparam int RUN_W  = 32;
  localparam int BITS_W = 7;
  localparam int TOT_W  = 48;

  // Run split into whole groups and a remainder
  localparam int GRP_W       = 27;
  localparam int REM_W       = CNT_W + 1;
  localparam int RECIP_W     = 33;
  localparam int RECIP_SHIFT = 38;
  // floor(2^38 / 63)
  localparam logic [RECIP_W-1:0] RECIP = 33'd4363141380;

  localparam logic [CNT_W-1:0]  GROUP_BITS = 6'd63;
  localparam logic [BITS_W-1:0] BLOCK_MAX  = 7'd64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BLOCK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QCNT_W  = 2;

  typedef enum logic [1:0] {
    KIND_RUN,
    KIND_BLOCK,
    KIND_FLUSH
  } wahenc_kind_t;

  typedef enum logic {
    PH_HEAD,
    PH_REST
  } wahenc_phase_t;

  typedef struct packed {
    wahenc_kind_t        kind;
    logic                bit_value;
    logic [RUN_W-1:0]    run_length;
    logic [GRP_W-1:0]    run_groups;
    logic [CNT_W-1:0]    run_rest;
    logic [WORD_W-1:0]   block_value;
    logic [BITS_W-1:0]   block_bits;
  } wahenc_entry_t;

  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } wahenc_qstat_t;

endpackage
`default_nettype wire

[rtl/core/wahenc_if.sv]
`default_nettype none
// Command channel
interface wahenc_item_if import wahenc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic              bit_value;
  logic [RUN_W-1:0]  run_length;
  logic [WORD_W-1:0] block_value;
  logic [BITS_W-1:0] block_bits;

  modport source (output valid, cmd, bit_value, run_length, block_value, block_bits,
                  input ready);
  modport sink (input valid, cmd, bit_value, run_length, block_value, block_bits,
                output ready);
endinterface

// Code word channel
interface wahenc_word_if import wahenc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] code_word;
  logic              is_tail;
  logic [CNT_W-1:0]  tail_bits;
  logic [TOT_W-1:0]  total_bits;
  logic              last;

  modport source (output valid, code_word, is_tail, tail_bits, total_bits, last,
                  input ready);
  modport sink (input valid, code_word, is_tail, tail_bits, total_bits, last,
                output ready);
endinterface
`default_nettype wire

[rtl/core/wahenc_front.sv]
`default_nettype none
module wahenc_front import wahenc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  wahenc_item_if.sink   items,
  input  wahenc_qstat_t qstat,
  output logic          push,
  output wahenc_entry_t entry
);

  logic                      s1_valid;
  wahenc_entry_t             s1;
  logic                      keep;
  wahenc_kind_t              kind;
  logic [BITS_W-1:0]         bits_clamped;
  logic [RUN_W+RECIP_W-1:0]  product;
  logic [RUN_W-1:0]          back_mul;
  logic [RUN_W-1:0]          rem_full;
  logic [REM_W-1:0]          rem;
  logic [REM_W-1:0]          rem_low;
  logic                      rem_wrap;
  logic                      accept;

  assign push        = s1_valid && !qstat.full;
  assign items.ready = !s1_valid || !qstat.full;
  assign accept      = items.valid && items.ready;

  // Classify the command and drop the ones that change nothing
  always_comb begin
    kind = KIND_RUN;
    keep = 1'b0;
    bits_clamped = (items.block_bits > BLOCK_MAX) ? BLOCK_MAX : items.block_bits;
    unique case (items.cmd)
      CMD_RUN: begin
        kind = KIND_RUN;
        keep = items.run_length != '0;
      end
      CMD_BLOCK: begin
        kind = KIND_BLOCK;
        keep = items.block_bits != '0;
      end
      CMD_FLUSH: begin
        kind = KIND_FLUSH;
        keep = 1'b1;
      end
      default: begin
        kind = KIND_RUN;
        keep = 1'b0;
      end
    endcase
  end

  // Estimate run / 63 by reciprocal; low by at most one
  assign product = (RUN_W+RECIP_W)'(items.run_length) * (RUN_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= keep;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.kind        <= kind;
      s1.bit_value   <= items.bit_value;
      s1.run_length  <= items.run_length;
      s1.run_groups  <= product[RECIP_SHIFT +: GRP_W];
      s1.run_rest    <= '0;
      s1.block_value <= items.block_value;
      s1.block_bits  <= bits_clamped;
    end
  end

  // Correct the quotient with one compare and subtract
  assign back_mul = (RUN_W'(s1.run_groups) << CNT_W) - RUN_W'(s1.run_groups);
  assign rem_full = s1.run_length - back_mul;
  assign rem      = rem_full[REM_W-1:0];
  assign rem_wrap = rem >= REM_W'(GROUP_BITS);
  assign rem_low  = rem - REM_W'(GROUP_BITS);

  always_comb begin
    entry = s1;
    entry.run_groups = rem_wrap ? s1.run_groups + GRP_W'(1) : s1.run_groups;
    entry.run_rest   = rem_wrap ? rem_low[CNT_W-1:0] : rem[CNT_W-1:0];
  end

endmodule
`default_nettype wire

[rtl/core/wahenc_queue.sv]
`default_nettype none
module wahenc_queue import wahenc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wahenc_entry_t push_entry,
  input  logic          pop,
  output logic          head_valid,
  output wahenc_entry_t head,
  output wahenc_qstat_t qstat
);

  localparam int QIDX_W = $clog2(Q_DEPTH);

  wahenc_entry_t     slots [Q_DEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QIDX_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QIDX_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head       = slots[rd_ptr];
  assign head_valid = count != '0;
  assign qstat.full  = count == QCNT_W'(Q_DEPTH);
  assign qstat.count = count;

endmodule
`default_nettype wire

[rtl/core/wahenc_back.sv]
`default_nettype none
module wahenc_back import wahenc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  wahenc_entry_t head,
  output logic          pop,
  wahenc_word_if.source words
);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              emit;
    logic [WORD_W-1:0] out;
  } wahenc_fin_t;

  // Close a full group: merge into the held fill or push a new word
  function automatic wahenc_fin_t finish_group(input logic [WORD_W-1:0] hw,
                                               input logic              hv,
                                               input logic [LIT_W-1:0]  grp);
    wahenc_fin_t f;
    logic        uniform;
    logic        fbit;
    uniform = (grp == '0) || (&grp);
    fbit    = grp[0];
    f.emit  = hv;
    f.out   = hw;
    if (uniform) begin
      if (hv && hw[WORD_W-1] && (hw[WORD_W-2] == fbit) && !(&hw[FCNT_W-1:0])) begin
        f.emit = 1'b0;
        f.word = {hw[WORD_W-1:FCNT_W], hw[FCNT_W-1:0] + FCNT_W'(1)};
      end else begin
        f.word = {1'b1, fbit, FCNT_W'(1)};
      end
    end else begin
      f.word = {1'b0, grp};
    end
    return f;
  endfunction

  // Encoder state
  logic [WORD_W-1:0] held_word, held_word_next;
  logic              held_valid, held_valid_next;
  logic [LIT_W-1:0]  lit, lit_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              started, started_next;
  logic [TOT_W-1:0]  bit_total, bit_total_next;
  wahenc_phase_t     phase, phase_next;
  logic [CNT_W-1:0]  rest_c, rest_c_next;

  // Staging and output registers
  logic              stg_valid;
  logic              stg_fin;
  logic [WORD_W-1:0] stg_word;
  logic              stg_tail;
  logic [CNT_W-1:0]  stg_tbits;
  logic [TOT_W-1:0]  stg_total;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic              out_tail;
  logic [CNT_W-1:0]  out_tbits;
  logic [TOT_W-1:0]  out_total;
  logic              out_last;

  // Step results
  logic              emit;
  logic [WORD_W-1:0] e_word;
  logic              e_tail;
  logic [CNT_W-1:0]  e_tbits;
  logic              done;
  logic [TOT_W-1:0]  item_total;

  // Datapath
  logic              is_run;
  logic [TOT_W:0]    tot_sum;
  logic [TOT_W-1:0]  total_sat;
  logic [CNT_W-1:0]  avail;
  logic              over;
  logic [LIT_W-1:0]  run_ins;
  logic [LIT_W-1:0]  blk_ins;
  logic [LIT_W-1:0]  high_fill;
  logic [LIT_W-1:0]  blk_full;
  logic [LIT_W-1:0]  fin_lit;
  logic [CNT_W-1:0]  len6;
  wahenc_fin_t       fin;
  logic [REM_W-1:0]  s_sum;
  logic [REM_W-1:0]  s_low;
  logic              s_wrap;
  logic [GRP_W-1:0]  fills;
  logic [CNT_W-1:0]  partial;
  logic [FCNT_W:0]   fsum;
  logic              fill_merge;
  logic [CNT_W-1:0]  inj;
  logic [BITS_W-1:0] blk_rem;
  logic [WORD_W-1:0] blk_shifted;
  logic [LIT_W-1:0]  rest_lit;
  logic              full_group;

  logic out_free;
  logic step_go;
  logic stg_move;
  logic move_last;

  assign is_run     = head.kind == KIND_RUN;
  assign full_group = started && (cnt == GROUP_BITS);

  // Saturating bit count after this item
  assign tot_sum   = (TOT_W+1)'(bit_total) +
                     (is_run ? (TOT_W+1)'(head.run_length) : (TOT_W+1)'(head.block_bits));
  assign total_sat = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];

  // Room in the active group and the bits that go into it
  assign avail     = GROUP_BITS - cnt;
  assign over      = is_run ? (head.run_length > RUN_W'(avail))
                            : (head.block_bits > BITS_W'(avail));
  assign len6      = is_run ? head.run_length[CNT_W-1:0] : head.block_bits[CNT_W-1:0];
  assign run_ins   = head.bit_value
                   ? (~({LIT_W{1'b1}} << head.run_length[CNT_W-1:0]) << cnt) : '0;
  assign blk_ins   = (head.block_value[LIT_W-1:0] &
                      ~({LIT_W{1'b1}} << head.block_bits[CNT_W-1:0])) << cnt;
  assign high_fill = head.bit_value ? ({LIT_W{1'b1}} << cnt) : '0;
  assign blk_full  = head.block_value[LIT_W-1:0] << cnt;
  assign fin_lit   = full_group ? lit : (lit | (is_run ? high_fill : blk_full));
  assign fin       = finish_group(held_word, held_valid, fin_lit);

  // Whole groups and remainder left after the first group closes
  assign s_sum      = REM_W'(rest_c) + REM_W'(head.run_rest);
  assign s_wrap     = s_sum >= REM_W'(GROUP_BITS);
  assign s_low      = s_sum - REM_W'(GROUP_BITS);
  assign fills      = s_wrap ? head.run_groups : head.run_groups - GRP_W'(1);
  assign partial    = s_wrap ? s_low[CNT_W-1:0] : s_sum[CNT_W-1:0];
  assign fsum       = (FCNT_W+1)'(held_word[FCNT_W-1:0]) + (FCNT_W+1)'(fills);
  assign fill_merge = held_valid && held_word[WORD_W-1] &&
                      (held_word[WORD_W-2] == head.bit_value) && !fsum[FCNT_W];

  // Block bits left after the first group closes
  assign inj         = GROUP_BITS - rest_c;
  assign blk_rem     = head.block_bits - BITS_W'(inj);
  assign blk_shifted = head.block_value >> inj;
  assign rest_lit    = blk_shifted[LIT_W-1:0] &
                       ~({LIT_W{1'b1}} << blk_rem[CNT_W-1:0]);

  // Next state and the word, if any, that this step finishes
  always_comb begin
    held_word_next  = held_word;
    held_valid_next = held_valid;
    lit_next        = lit;
    cnt_next        = cnt;
    started_next    = started;
    bit_total_next  = bit_total;
    phase_next      = phase;
    rest_c_next     = rest_c;
    emit            = 1'b0;
    e_word          = held_word;
    e_tail          = 1'b0;
    e_tbits         = '0;
    done            = 1'b0;
    item_total      = bit_total;
    unique case (head.kind) inside
      KIND_FLUSH: begin
        if (held_valid) begin
          emit            = 1'b1;
          held_valid_next = 1'b0;
        end else begin
          done = 1'b1;
          if (started) begin
            emit    = 1'b1;
            e_word  = {1'b0, lit};
            e_tail  = 1'b1;
            e_tbits = cnt;
          end
          held_word_next = '0;
          lit_next       = '0;
          cnt_next       = '0;
          started_next   = 1'b0;
          bit_total_next = '0;
          phase_next     = PH_HEAD;
        end
      end
      KIND_RUN, KIND_BLOCK: begin
        if (full_group) begin
          item_total      = total_sat;
          emit            = fin.emit;
          e_word          = fin.out;
          held_word_next  = fin.word;
          held_valid_next = 1'b1;
          lit_next        = '0;
          cnt_next        = '0;
        end else if (phase == PH_HEAD) begin
          item_total     = total_sat;
          started_next   = 1'b1;
          bit_total_next = total_sat;
          if (over) begin
            emit            = fin.emit;
            e_word          = fin.out;
            held_word_next  = fin.word;
            held_valid_next = 1'b1;
            lit_next        = '0;
            cnt_next        = '0;
            rest_c_next     = cnt;
            phase_next      = PH_REST;
          end else begin
            done     = 1'b1;
            lit_next = lit | (is_run ? run_ins : blk_ins);
            cnt_next = cnt + len6;
          end
        end else begin
          done       = 1'b1;
          phase_next = PH_HEAD;
          if (is_run) begin
            if (fills != '0) begin
              if (fill_merge) begin
                held_word_next = {held_word[WORD_W-1:FCNT_W], fsum[FCNT_W-1:0]};
              end else begin
                emit            = held_valid;
                held_word_next  = {1'b1, head.bit_value, FCNT_W'(fills)};
                held_valid_next = 1'b1;
              end
            end
            lit_next = head.bit_value ? ~({LIT_W{1'b1}} << partial) : '0;
            cnt_next = partial;
          end else begin
            lit_next = rest_lit;
            cnt_next = blk_rem[CNT_W-1:0];
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // Hold a step while the staged word cannot move on
  assign out_free  = !out_valid || words.ready;
  assign step_go   = head_valid && (!stg_valid || out_free);
  assign pop       = step_go && done;
  assign stg_move  = stg_valid && out_free && (stg_fin || (step_go && (emit || done)));
  assign move_last = stg_fin || (step_go && done && !emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_word  <= '0;
      held_valid <= 1'b0;
      lit        <= '0;
      cnt        <= '0;
      started    <= 1'b0;
      bit_total  <= '0;
      phase      <= PH_HEAD;
      rest_c     <= '0;
    end else if (step_go) begin
      held_word  <= held_word_next;
      held_valid <= held_valid_next;
      lit        <= lit_next;
      cnt        <= cnt_next;
      started    <= started_next;
      bit_total  <= bit_total_next;
      phase      <= phase_next;
      rest_c     <= rest_c_next;
    end
  end

  // Stage each word until it is known whether it ends its transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      stg_fin   <= 1'b0;
    end else if (step_go && emit) begin
      stg_valid <= 1'b1;
      stg_fin   <= done;
    end else if (stg_move) begin
      stg_valid <= 1'b0;
      stg_fin   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && emit) begin
      stg_word  <= e_word;
      stg_tail  <= e_tail;
      stg_tbits <= e_tbits;
      stg_total <= item_total;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stg_move) begin
      out_valid <= 1'b1;
    end else if (words.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_move) begin
      out_word  <= stg_word;
      out_tail  <= stg_tail;
      out_tbits <= stg_tbits;
      out_total <= stg_total;
      out_last  <= move_last;
    end
  end

  assign words.valid      = out_valid;
  assign words.code_word  = out_word;
  assign words.is_tail    = out_tail;
  assign words.tail_bits  = out_tbits;
  assign words.total_bits = out_total;
  assign words.last       = out_last;

endmodule
`default_nettype wire

[rtl/core/wah_bitmap_encoder_top.sv]
`default_nettype none
// Channel  Role    Handshake    Transaction
// items    sink    valid/ready  one command: run, block or flush
// words    source  valid/ready  one finished code word with running bit count
//
// A command is taken every cycle while the two-entry queue has room; the
// encode stage closes the active group before it places the bits that do not
// fit, and first closes a group that was already full. A flush emits the held
// word, if any, before the tail word. A full group is closed by the single
// group-closing unit, which updates the held word once a cycle while a step
// can go. rst clears the encoder, the queue and both output registers.
// A low words.ready fills the staging and output registers, then the queue,
// then drops items.ready.
module wah_bitmap_encoder_top import wahenc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  wahenc_item_if.sink   items,
  wahenc_word_if.source words
);

  logic          q_push;
  wahenc_entry_t q_entry;
  logic          q_pop;
  logic          q_head_valid;
  wahenc_entry_t q_head;
  wahenc_qstat_t qstat;

  wahenc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .qstat (qstat),
    .push  (q_push),
    .entry (q_entry)
  );

  wahenc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head),
    .qstat      (qstat)
  );

  wahenc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .words      (words)
  );

  // A tail is always a literal
  a_tail_literal: assert property (@(posedge clk) disable iff (rst)
    words.valid && words.is_tail |-> !words.code_word[WORD_W-1])
    else $error("tail word carries a fill flag");

  // A tail closes its flush
  a_tail_last: assert property (@(posedge clk) disable iff (rst)
    words.valid && words.is_tail |-> words.last)
    else $error("tail word not marked last");

  // Only a tail reports a bit count
  a_tail_bits: assert property (@(posedge clk) disable iff (rst)
    words.valid && !words.is_tail |-> words.tail_bits == '0)
    else $error("non-tail word with tail bit count");

  // Never push into a full queue
  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full && (qstat.count < QCNT_W'(Q_DEPTH)))
    else $error("queue overrun");

endmodule
`default_nettype wire

[verif/tb_wah_bitmap_encoder_top.sv]
module tb_wah_bitmap_encoder_top;
  import wahenc_pkg::*;

  localparam int          RANDOM_ITEMS  = 330;
  localparam int          LONG_RUNS     = 6;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT   = 100000;

  // Command code outside the defined set, must be ignored
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [63:0] LIT_MASK  = {1'b0, {63{1'b1}}};
  localparam logic [63:0] FILL_FLAG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] FILL_ONE  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] FILL_MAX  = FILL_ONE - 64'd1;
  localparam logic [63:0] TOTAL_MAX = {16'd0, {48{1'b1}}};
  localparam logic [63:0] GROUP     = 64'd63;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              bit_value;
    logic [RUN_W-1:0]  run_length;
    logic [WORD_W-1:0] block_value;
    logic [BITS_W-1:0] block_bits;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] code_word;
    logic              is_tail;
    logic [CNT_W-1:0]  tail_bits;
    logic [TOT_W-1:0]  total_bits;
    logic              last;
  } word_t;

  // A directed row: n_typed < 0 leaves the expectation to the encoder model
  typedef struct packed {
    item_t          stim;
    int             n_typed;
    word_t [0:1]    typed;
  } row_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_SPARSE,
    SINK_BLOCKED
  } sink_mode_t;

  localparam word_t NO_WORD = '0;
  localparam int    N_DIR   = 23;

  localparam row_t DIR_ROWS [N_DIR] = '{
    // flush before any bit: nothing comes out
    '{'{CMD_FLUSH, 1'b0, 32'd0, 64'd0, 7'd0}, 0, '{NO_WORD, NO_WORD}},
    // unknown command with every field set
    '{'{CMD_UNUSED, 1'b1, 32'hFFFF_FFFF, {64{1'b1}}, 7'd127}, 0, '{NO_WORD, NO_WORD}},
    // empty run and empty block
    '{'{CMD_RUN, 1'b1, 32'd0, 64'd0, 7'd5}, 0, '{NO_WORD, NO_WORD}},
    '{'{CMD_BLOCK, 1'b0, 32'd9, {64{1'b1}}, 7'd0}, 0, '{NO_WORD, NO_WORD}},
    // two zero groups merge into one held fill; tail is empty
    '{'{CMD_RUN, 1'b0, 32'd126, 64'd0, 7'd0}, 0, '{NO_WORD, NO_WORD}},
    '{'{CMD_FLUSH, 1'b0, 32'd0, 64'd0, 7'd0}, 2,
      '{'{64'h8000_0000_0000_0002, 1'b0, 6'd0, 48'd126, 1'b0},
        '{64'd0, 1'b1, 6'd0, 48'd126, 1'b1}}},
    // full 64-bit block of ones: one-fill held, one bit spills over
    '{'{CMD_BLOCK, 1'b0, 32'd0, {64{1'b1}}, 7'd64}, 0, '{NO_WORD, NO_WORD}},
    '{'{CMD_FLUSH, 1'b0, 32'd0, 64'd0, 7'd0}, 2,
      '{'{64'hC000_0000_0000_0001, 1'b0, 6'd0, 48'd64, 1'b0},
        '{64'd1, 1'b1, 6'd1, 48'd64, 1'b1}}},
    // active word exactly full at flush
    '{'{CMD_BLOCK, 1'b1, 32'd0, 64'h5555_5555_5555_5555, 7'd63}, 0, '{NO_WORD, NO_WORD}},
    '{'{CMD_FLUSH, 1'b0, 32'd0, 64'd0, 7'd0}, 1,
      '{'{64'h5555_5555_5555_5555, 1'b1, 6'd63, 48'd63, 1'b1}, NO_WORD}},
    // oversized blocks are cut to a full word
    '{'{CMD_BLOCK, 1'b0, 32'd0, 64'hAAAA_AAAA_AAAA_AAAA, 7'd127}, 0, '{NO_WORD, NO_WORD}},
    '{'{CMD_BLOCK, 1'b1, 32'd0, 64'd0, 7'd65}, 1,
      '{'{64'h2AAA_AAAA_AAAA_AAAA, 1'b0, 6'd0, 48'd128, 1'b1}, NO_WORD}},
    '{'{CMD_BLOCK, 1'b0, 32'd0, 64'h0123_4567_89AB_CDEF, 7'd61}, -1, '{NO_WORD, NO_WORD}},
    '{'{CMD_RUN, 1'b1, 32'd200, 64'd0, 7'd0}, -1, '{NO_WORD, NO_WORD}},
    '{'{CMD_RUN, 1'b1, 32'hFFFF_FFFF, 64'd0, 7'd0}, -1, '{NO_WORD, NO_WORD}},
    '{'{CMD_RUN, 1'b0, 32'hFFFF_FFFF, 64'd0, 7'd0}, -1, '{NO_WORD, NO_WORD}},
    '{'{CMD_RUN, 1'b0, 32'd63, 64'd0, 7'd0}, -1, '{NO_WORD, NO_WORD}},
    '{'{CMD_BLOCK, 1'b0, 32'd0, 64'd0, 7'd64}, -1, '{NO_WORD, NO_WORD}},
    '{'{CMD_BLOCK, 1'b0, 32'd0, 64'd1, 7'd1}, -1, '{NO_WORD, NO_WORD}},
    '{'{CMD_RUN, 1'b1, 32'd1, 64'd0, 7'd0}, -1, '{NO_WORD, NO_WORD}},
    '{'{CMD_FLUSH, 1'b1, 32'hFFFF_FFFF, {64{1'b1}}, 7'd127}, -1, '{NO_WORD, NO_WORD}},
    // one group of ones left active at flush
    '{'{CMD_RUN, 1'b1, 32'd63, 64'd0, 7'd0}, 0, '{NO_WORD, NO_WORD}},
    '{'{CMD_FLUSH, 1'b0, 32'd0, 64'd0, 7'd0}, 1,
      '{'{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd63, 48'd63, 1'b1}, NO_WORD}}
  };

  logic clk = 1'b0;
  logic rst;

  wahenc_item_if items ();
  wahenc_word_if words ();

  wah_bitmap_encoder_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .words (words)
  );

  always #5 clk = ~clk;

  // Encoder model state
  logic [63:0] enc_held_word;
  bit          enc_held_ok;
  logic [63:0] enc_lit;
  logic [63:0] enc_count;
  bit          enc_started;
  logic [63:0] enc_total;

  word_t       step_words [$];
  word_t       expected_words [$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        fav_bit = 1'b0;
  int          burst_left = 0;
  bit          steady = 1'b0;

  function automatic logic [63:0] ones_below(input logic [63:0] k);
    if (k >= 64) return '1;
    return (64'd1 << k) - 64'd1;
  endfunction

  function automatic logic [63:0] fill_word(input logic b, input logic [63:0] groups);
    return FILL_FLAG | (b ? FILL_ONE : 64'd0) | (groups & FILL_MAX);
  endfunction

  function automatic bit is_fill_of(input logic [63:0] w, input logic b);
    return w[63] && (w[62] == b);
  endfunction

  function automatic void bump_total(input logic [63:0] x);
    if (enc_total + x > TOTAL_MAX) enc_total = TOTAL_MAX;
    else enc_total = enc_total + x;
  endfunction

  function automatic void emit_word(input logic [63:0] w, input logic tail,
                                    input logic [63:0] tbits);
    word_t r;
    if (step_words.size() >= 3) return;
    r = '0;
    r.code_word = w;
    r.is_tail   = tail;
    r.tail_bits = tbits[CNT_W-1:0];
    step_words.insert(step_words.size(), r);
  endfunction

  // Hold the newest finished word, release the one it displaces
  function automatic void retire_word(input logic [63:0] w);
    if (enc_held_ok) emit_word(enc_held_word, 1'b0, 64'd0);
    enc_held_word = w;
    enc_held_ok   = 1'b1;
  endfunction

  function automatic void close_group();
    logic [63:0] lit;
    logic        b;
    lit = enc_lit & LIT_MASK;
    if (lit == 64'd0 || lit == LIT_MASK) begin
      b = (lit != 64'd0);
      if (enc_held_ok && is_fill_of(enc_held_word, b) && (enc_held_word & FILL_MAX) < FILL_MAX)
        enc_held_word = fill_word(b, (enc_held_word & FILL_MAX) + 64'd1);
      else
        retire_word(fill_word(b, 64'd1));
    end else begin
      retire_word(lit);
    end
    enc_lit   = 64'd0;
    enc_count = 64'd0;
  endfunction

  function automatic void open_append();
    if (!enc_started) enc_started = 1'b1;
    else if (enc_count >= GROUP) close_group();
  endfunction

  function automatic void append_run(input logic b, input logic [63:0] n);
    logic [63:0] take;
    logic [63:0] left;
    logic [63:0] groups;
    logic [63:0] rest;
    if (n == 64'd0) return;
    open_append();
    take = (n < GROUP - enc_count) ? n : GROUP - enc_count;
    if (b) enc_lit = enc_lit | (ones_below(take) << enc_count);
    enc_lit   = enc_lit & LIT_MASK;
    enc_count = enc_count + take;
    bump_total(take);
    if (n <= take) return;
    close_group();
    left   = n - take;
    groups = left / GROUP;
    rest   = left % GROUP;
    // whole groups go straight into a fill, merged where the count fits
    if (groups > 64'd0) begin
      if (enc_held_ok && is_fill_of(enc_held_word, b) &&
          (enc_held_word & FILL_MAX) + groups <= FILL_MAX) begin
        enc_held_word = fill_word(b, (enc_held_word & FILL_MAX) + groups);
      end else begin
        if (groups > FILL_MAX) groups = FILL_MAX;
        retire_word(fill_word(b, groups));
      end
      bump_total(groups * GROUP);
    end
    enc_lit   = b ? ones_below(rest) : 64'd0;
    enc_count = rest;
    bump_total(rest);
  endfunction

  function automatic void add_block(input logic [63:0] value, input logic [63:0] nbits);
    logic [63:0] bits_in;
    logic [63:0] take;
    logic [63:0] rest;
    if (nbits == 64'd0) return;
    bits_in = (nbits > 64'd64) ? 64'd64 : nbits;
    open_append();
    take = (bits_in < GROUP - enc_count) ? bits_in : GROUP - enc_count;
    enc_lit   = (enc_lit | ((value & ones_below(take)) << enc_count)) & LIT_MASK;
    enc_count = enc_count + take;
    bump_total(take);
    if (bits_in <= take) return;
    close_group();
    rest      = bits_in - take;
    enc_lit   = (value >> take) & ones_below(rest) & LIT_MASK;
    enc_count = rest;
    bump_total(rest);
  endfunction

  function automatic void clear_encoder();
    enc_held_word = 64'd0;
    enc_held_ok   = 1'b0;
    enc_lit       = 64'd0;
    enc_count     = 64'd0;
    enc_started   = 1'b0;
    enc_total     = 64'd0;
  endfunction

  // Work out the words one command produces, into step_words
  function automatic void encode_item(input item_t it);
    step_words.delete();
    case (it.cmd)
      CMD_RUN:   append_run(it.bit_value, 64'(it.run_length));
      CMD_BLOCK: add_block(it.block_value, 64'(it.block_bits));
      CMD_FLUSH: begin
        if (enc_held_ok) emit_word(enc_held_word, 1'b0, 64'd0);
        if (enc_started) emit_word(enc_lit & LIT_MASK, 1'b1, enc_count);
      end
      default: ;
    endcase
    foreach (step_words[k]) begin
      step_words[k].total_bits = enc_total[TOT_W-1:0];
      step_words[k].last       = (k == step_words.size() - 1);
    end
    if (it.cmd == CMD_FLUSH) clear_encoder();
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 44)      it.cmd = CMD_RUN;
    else if (pick < 86) it.cmd = CMD_BLOCK;
    else if (pick < 95) it.cmd = CMD_FLUSH;
    else                it.cmd = CMD_UNUSED;
    // keep one bit value for a while so that fills get to merge
    if ($urandom_range(0, 4) == 0) fav_bit = ~fav_bit;
    it.bit_value = fav_bit;
    pick = $urandom_range(0, 19);
    if (pick == 0)       it.run_length = '0;
    else if (pick < 10)  it.run_length = $urandom_range(1, 70);
    else if (pick < 14)  it.run_length = 63 * $urandom_range(1, 4);
    else if (pick < 17)  it.run_length = $urandom_range(64, 400);
    else if (pick == 17) it.run_length = $urandom_range(1000, 200000);
    else if (pick == 18) it.run_length = $urandom;
    else                 it.run_length = 32'hFFFF_FFFF - $urandom_range(0, 63);
    pick = $urandom_range(0, 9);
    if (pick < 6)      it.block_value = {$urandom, $urandom};
    else if (pick < 9) it.block_value = fav_bit ? '1 : '0;
    else               it.block_value = {$urandom, $urandom} | {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick == 0)     it.block_bits = '0;
    else if (pick == 1) it.block_bits = $urandom_range(65, 127);
    else if (pick < 5) it.block_bits = $urandom_range(63, 64);
    else               it.block_bits = $urandom_range(1, 64);
    return it;
  endfunction

  // Present one command, hold it until taken, then queue its model words if asked
  task automatic send_item(input item_t it, input bit from_model);
    items.valid       <= 1'b1;
    items.cmd         <= it.cmd;
    items.bit_value   <= it.bit_value;
    items.run_length  <= it.run_length;
    items.block_value <= it.block_value;
    items.block_bits  <= it.block_bits;
    do @(posedge clk); while (!items.ready);
    encode_item(it);
    if (from_model)
      foreach (step_words[k]) expected_words.insert(expected_words.size(), step_words[k]);
  endtask

  // Burst pacing: a random gap after most bursts, none in steady phases
  task automatic pace_sender();
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver stall pattern
  logic       sink_ready = 1'b0;
  sink_mode_t sink_mode  = SINK_OPEN;
  int         mode_left  = 0;
  logic [4:0] stall_phase = '0;

  assign words.ready = sink_ready;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left <= $urandom_range(20, 120);
      sink_mode <= sink_mode_t'($urandom_range(0, 3));
    end else begin
      mode_left <= mode_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:   sink_ready <= 1'b1;
      SINK_LIGHT:  sink_ready <= ($urandom_range(0, 3) != 0);
      SINK_SPARSE: sink_ready <= (stall_phase[2:0] == 3'd0);
      default:     sink_ready <= stall_phase[4];
    endcase
    stall_phase <= stall_phase + 5'd1;
  end

  // Compare each word taken against the oldest expectation
  always @(posedge clk) begin : check_words
    word_t want;
    if (!rst && words.valid && words.ready) begin
      if (expected_words.size() == 0) begin
        $error("code_word: expected none, got %h", words.code_word);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        if (words.code_word !== want.code_word) begin
          $error("code_word: expected %h, got %h", want.code_word, words.code_word);
          mismatch_count++;
        end
        if (words.is_tail !== want.is_tail) begin
          $error("is_tail: expected %0d, got %0d", want.is_tail, words.is_tail);
          mismatch_count++;
        end
        if (words.tail_bits !== want.tail_bits) begin
          $error("tail_bits: expected %0d, got %0d", want.tail_bits, words.tail_bits);
          mismatch_count++;
        end
        if (words.total_bits !== want.total_bits) begin
          $error("total_bits: expected %0d, got %0d", want.total_bits, words.total_bits);
          mismatch_count++;
        end
        if (words.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, words.last);
          mismatch_count++;
        end
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_wah_bitmap_encoder_top: errors");
      $finish;
    end
  end

  initial begin
    item_t it;
    int    n_random;
    rst               <= 1'b1;
    items.valid       <= 1'b0;
    items.cmd         <= CMD_RUN;
    items.bit_value   <= 1'b0;
    items.run_length  <= '0;
    items.block_value <= '0;
    items.block_bits  <= '0;
    clear_encoder();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (DIR_ROWS[i]) begin
      send_item(DIR_ROWS[i].stim, DIR_ROWS[i].n_typed < 0);
      for (int k = 0; k < DIR_ROWS[i].n_typed; k++)
        expected_words.insert(expected_words.size(), DIR_ROWS[i].typed[k]);
      pace_sender();
    end

    // Random commands
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      it = random_item();
      send_item(it, 1'b1);
      n_random++;
      pace_sender();
    end

    // Finish with a flush, back-to-back maximal runs, a full block and a flush
    steady = 1'b1;
    it = '0;
    it.cmd = CMD_FLUSH;
    send_item(it, 1'b1);
    it.cmd        = CMD_RUN;
    it.bit_value  = 1'b1;
    it.run_length = 32'hFFFF_FFFF;
    for (int k = 0; k < LONG_RUNS; k++) begin
      it.block_value = {$urandom, $urandom};
      send_item(it, 1'b1);
    end
    it.cmd         = CMD_BLOCK;
    it.block_value = {$urandom, $urandom};
    it.block_bits  = 7'd64;
    send_item(it, 1'b1);
    it.cmd = CMD_FLUSH;
    send_item(it, 1'b1);
    items.valid <= 1'b0;

    // Drain, then allow stray words time to show up
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_wah_bitmap_encoder_top: clean");
    else
      $display("tb_wah_bitmap_encoder_top: errors");
    $finish;
  end

endmodule

[wah_bitmap_encoder_top.f]
rtl/core/wahenc_pkg.sv
rtl/core/wahenc_if.sv
rtl/core/wahenc_front.sv
rtl/core/wahenc_queue.sv
rtl/core/wahenc_back.sv
rtl/core/wah_bitmap_encoder_top.sv
verif/tb_wah_bitmap_encoder_top.sv
